FILE: rtl/cfa_pkg.sv
// ----------------------------------------------------------------------------
// cfa_pkg: shared types, codes and helpers for the calendar field adjuster
// Field selector codes, clock chip register addresses, the request and
// result records, and the small arithmetic helpers (BCD, month length, range step).
// ----------------------------------------------------------------------------
package cfa_pkg;

  // Device write address, opens every write sequence
  localparam logic [7:0] DevWriteAddr = 8'hD0;

  // Field selector codes
  typedef enum logic [2:0] {
    SEL_NONE    = 3'd0,
    SEL_DATE    = 3'd1,
    SEL_MONTH   = 3'd2,
    SEL_YEAR    = 3'd3,
    SEL_WEEKDAY = 3'd4,
    SEL_HOUR    = 3'd5,
    SEL_MINUTE  = 3'd6,
    SEL_SECOND  = 3'd7
  } field_sel_e;

  // Clock chip register addresses
  localparam logic [2:0] RegSecond  = 3'd0;
  localparam logic [2:0] RegMinute  = 3'd1;
  localparam logic [2:0] RegHour    = 3'd2;
  localparam logic [2:0] RegWeekday = 3'd3;
  localparam logic [2:0] RegDate    = 3'd4;
  localparam logic [2:0] RegMonth   = 3'd5;
  localparam logic [2:0] RegYear    = 3'd6;

  // Field limits
  localparam logic [6:0] MaxYear    = 7'd99;
  localparam logic [6:0] MaxMonth   = 7'd12;
  localparam logic [6:0] MaxWeekday = 7'd7;
  localparam logic [6:0] MaxHour    = 7'd23;
  localparam logic [6:0] MaxMinute  = 7'd59;
  localparam logic [6:0] SecondDown = 7'd30;

  localparam int unsigned InDataW = 40;

  // One request as packed on the input stream
  typedef struct packed {
    logic [6:0] cur_year;
    logic [3:0] cur_month;
    logic [4:0] cur_date;
    logic [2:0] cur_weekday;
    logic [4:0] cur_hour;
    logic [5:0] cur_minute;
    logic       go_up;
    logic [2:0] field_select;
  } cfa_req_t;

  // Computed write sequence for one request
  typedef struct packed {
    logic       addr_only;
    logic [2:0] reg_addr;
    logic [7:0] bcd_val;
  } cfa_res_t;

  // Packed BCD of a value below 100; tens digit by reciprocal multiply
  function automatic logic [7:0] to_bcd(input logic [6:0] v);
    logic [17:0] prod;
    logic [3:0]  tens;
    logic [6:0]  units;
    prod  = 18'(v) * 18'd205;
    tens  = prod[14:11];
    units = v - 7'(tens * 4'd10);
    return {tens, units[3:0]};
  endfunction

  // Days in a month; out of range months count as 31 days
  function automatic logic [6:0] month_length(input logic [3:0] month,
                                              input logic [6:0] year);
    logic [6:0] len;
    len = 7'd31;
    if (month == 4'd2) begin
      len = (year[1:0] == 2'b00) ? 7'd29 : 7'd28;
    end else if (month == 4'd4 || month == 4'd6 || month == 4'd9 ||
                 month == 4'd11) begin
      len = 7'd30;
    end
    return len;
  endfunction

  // Step inside lo..hi with wraparound
  function automatic logic [6:0] step_range(input logic [6:0] v,
                                            input logic       up,
                                            input logic [6:0] lo,
                                            input logic [6:0] hi,
                                            input logic [6:0] up_wrap);
    logic [6:0] r;
    if (up) begin
      r = (v < hi) ? v + 7'd1 : up_wrap;
    end else begin
      r = (v > lo) ? v - 7'd1 : hi;
    end
    return r;
  endfunction

endpackage

FILE: rtl/calendar_field_adjust.sv
// ----------------------------------------------------------------------------
// calendar_field_adjust: clock chip calendar field step, write sequencer
// Steps one calendar field and emits the write bytes: device address,
// register address, new value in BCD.
//
//   channel   dir  tdata                        tuser        tlast
//   s_axis    in   request fields (40 bits)     -            -
//   m_axis    out  bus_byte (8 bits)            first_byte   last_byte
//
// A request passes an input register, then the step logic, then the result
// register, from which the bytes leave one per cycle unless m_axis stalls. A
// request with a field selected yields three transfers, one with no field
// selected yields one, so without stalls address-only requests go out one
// per cycle; the single output byte per cycle sets the request rate.
// Reset empties both registers. A stall on m_axis holds the current byte;
// the next request is taken while the previous one is still being sent.
// ----------------------------------------------------------------------------
module calendar_field_adjust (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // {cur_year, cur_month, cur_date, cur_weekday, cur_hour, cur_minute,
  //  go_up, field_select} from bit 0 up: field_select[2:0], go_up[3],
  //  cur_minute[9:4], cur_hour[14:10], cur_weekday[17:15], cur_date[22:18],
  //  cur_month[26:23], cur_year[33:27], zero fill [39:34]
  input  logic [cfa_pkg::InDataW-1:0]   s_axis_tdata_i,
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  // bus_byte[7:0]
  output logic [7:0]                    m_axis_tdata_o,
  // first_byte[0]
  output logic                          m_axis_tuser_o,
  output logic                          m_axis_tlast_o,
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i
);
  import cfa_pkg::*;

  typedef enum logic [1:0] {
    BYTE_DEV = 2'd0,
    BYTE_REG = 2'd1,
    BYTE_VAL = 2'd2
  } byte_pos_e;

  logic      in_valid_q;
  cfa_req_t  in_q;
  logic      res_valid_q;
  cfa_res_t  res_q;
  cfa_res_t  res_d;
  byte_pos_e pos_q;

  logic out_xfer;
  logic out_last;
  logic res_free;
  logic in_move;
  logic in_xfer;

  // Handshake control
  assign out_xfer = res_valid_q & m_axis_tready_i;
  assign out_last = res_q.addr_only ? (pos_q == BYTE_DEV) : (pos_q == BYTE_VAL);
  assign res_free = ~res_valid_q | (out_xfer & out_last);
  assign in_move  = in_valid_q & res_free;
  assign in_xfer  = s_axis_tvalid_i & s_axis_tready_o;

  assign s_axis_tready_o = ~in_valid_q | res_free;

  // Step logic between input and result registers
  cfa_step u_step (
    .req_i (in_q),
    .res_o (res_d)
  );

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      in_q <= cfa_req_t'(s_axis_tdata_i[$bits(cfa_req_t)-1:0]);
    end
  end

  // Result register and byte position
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
      pos_q       <= BYTE_DEV;
    end else begin
      if (res_free) begin
        res_valid_q <= in_valid_q;
        pos_q       <= BYTE_DEV;
      end else if (out_xfer) begin
        case (pos_q)
          BYTE_DEV: pos_q <= BYTE_REG;
          BYTE_REG: pos_q <= BYTE_VAL;
          default:  pos_q <= BYTE_DEV;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_move) begin
      res_q <= res_d;
    end
  end

  // Output byte select
  always_comb begin
    case (pos_q)
      BYTE_DEV: m_axis_tdata_o = DevWriteAddr;
      BYTE_REG: m_axis_tdata_o = {5'b0, res_q.reg_addr};
      BYTE_VAL: m_axis_tdata_o = res_q.bcd_val;
      default:  m_axis_tdata_o = '0;
    endcase
  end

  assign m_axis_tvalid_o = res_valid_q;
  assign m_axis_tuser_o  = (pos_q == BYTE_DEV);
  assign m_axis_tlast_o  = out_last;

endmodule

FILE: rtl/cfa_step.sv
// ----------------------------------------------------------------------------
// cfa_step: field step and BCD encode
// Picks the selected field, steps it up or down with wraparound (seconds go to
// 0 or 30) and returns the register address and the new value in packed BCD.
// ----------------------------------------------------------------------------
module cfa_step (
  input  cfa_pkg::cfa_req_t req_i,
  output cfa_pkg::cfa_res_t res_o
);
  import cfa_pkg::*;

  logic [6:0] new_val;
  logic [6:0] date_len;

  assign date_len = month_length(req_i.cur_month, req_i.cur_year);

  // Select and step the field, then encode the new value
  always_comb begin
    res_o.addr_only = 1'b0;
    res_o.reg_addr  = RegSecond;
    new_val         = '0;
    case (field_sel_e'(req_i.field_select))
      SEL_DATE: begin
        res_o.reg_addr = RegDate;
        new_val = step_range(7'(req_i.cur_date), req_i.go_up, 7'd1, date_len, 7'd1);
      end
      SEL_MONTH: begin
        res_o.reg_addr = RegMonth;
        new_val = step_range(7'(req_i.cur_month), req_i.go_up, 7'd1, MaxMonth, 7'd1);
      end
      SEL_YEAR: begin
        res_o.reg_addr = RegYear;
        new_val = step_range(req_i.cur_year, req_i.go_up, 7'd1, MaxYear, 7'd1);
      end
      SEL_WEEKDAY: begin
        res_o.reg_addr = RegWeekday;
        new_val = step_range(7'(req_i.cur_weekday), req_i.go_up, 7'd1, MaxWeekday,
                             7'd1);
      end
      SEL_HOUR: begin
        res_o.reg_addr = RegHour;
        new_val = step_range(7'(req_i.cur_hour), req_i.go_up, 7'd0, MaxHour, 7'd0);
      end
      SEL_MINUTE: begin
        res_o.reg_addr = RegMinute;
        new_val = step_range(7'(req_i.cur_minute), req_i.go_up, 7'd0, MaxMinute,
                             7'd0);
      end
      SEL_SECOND: begin
        res_o.reg_addr = RegSecond;
        new_val = req_i.go_up ? 7'd0 : SecondDown;
      end
      default: begin
        res_o.addr_only = 1'b1;
      end
    endcase
    res_o.bcd_val = to_bcd(new_val);
  end

endmodule

FILE: tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking bench for calendar_field_adjust
// Streams field-step requests into the block and predicts the write sequence
// each one should produce: the device address byte, then the register
// address and the stepped value in BCD. Each output transfer is checked in
// order against that prediction. Both stream sides pause at random. A middle
// stretch runs with no pauses at all.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import cfa_pkg::*;

  localparam int DataW        = cfa_pkg::InDataW;
  localparam int RandomCount  = 320;
  localparam int IdleLimit    = 2000;
  localparam int DrainCycles  = 16;

  // One byte of a write sequence as seen on m_axis
  typedef struct packed {
    logic [7:0] data;
    logic       is_first;
    logic       is_last;
  } bus_byte_t;

  // --------------------------------------------------------------------------
  // Scoreboard: predicts write sequences, checks output bytes in order
  // --------------------------------------------------------------------------
  class write_seq_board;
    bus_byte_t expected_bytes[$];
    int        errors = 0;

    function automatic logic [7:0] bcd_byte(int unsigned v);
      return 8'((((v / 10) << 4) | (v % 10)) & 'hFF);
    endfunction

    function automatic int unsigned days_in_month(int unsigned month,
                                                  int unsigned year);
      if (month == 2) begin
        return (year % 4 == 0) ? 29 : 28;
      end
      if (month == 4 || month == 6 || month == 9 || month == 11) begin
        return 30;
      end
      return 31;
    endfunction

    // Up wraps to wrap_to past hi; down wraps to hi at or below lo
    function automatic int unsigned step_wrap(int unsigned v, bit up,
                                              int unsigned lo, int unsigned hi,
                                              int unsigned wrap_to);
      if (up) begin
        return (v < hi) ? v + 1 : wrap_to;
      end
      return (v > lo) ? v - 1 : hi;
    endfunction

    // Queue the bytes an accepted request should produce
    function void note_request(cfa_req_t r);
      field_sel_e  sel;
      logic [2:0]  reg_addr;
      int unsigned nv;
      bus_byte_t   b;
      sel        = field_sel_e'(r.field_select);
      b.data     = DevWriteAddr;
      b.is_first = 1'b1;
      b.is_last  = (sel == SEL_NONE);
      expected_bytes.push_back(b);
      if (sel == SEL_NONE) return;
      case (sel)
        SEL_DATE: begin
          reg_addr = RegDate;
          nv = step_wrap(r.cur_date, r.go_up, 1,
                         days_in_month(r.cur_month, r.cur_year), 1);
        end
        SEL_MONTH: begin
          reg_addr = RegMonth;
          nv = step_wrap(r.cur_month, r.go_up, 1, MaxMonth, 1);
        end
        SEL_YEAR: begin
          reg_addr = RegYear;
          nv = step_wrap(r.cur_year, r.go_up, 1, MaxYear, 1);
        end
        SEL_WEEKDAY: begin
          reg_addr = RegWeekday;
          nv = step_wrap(r.cur_weekday, r.go_up, 1, MaxWeekday, 1);
        end
        SEL_HOUR: begin
          reg_addr = RegHour;
          nv = step_wrap(r.cur_hour, r.go_up, 0, MaxHour, 0);
        end
        SEL_MINUTE: begin
          reg_addr = RegMinute;
          nv = step_wrap(r.cur_minute, r.go_up, 0, MaxMinute, 0);
        end
        default: begin
          // seconds are not stepped, only set
          reg_addr = RegSecond;
          nv = r.go_up ? 0 : SecondDown;
        end
      endcase
      b.data     = 8'(reg_addr);
      b.is_first = 1'b0;
      b.is_last  = 1'b0;
      expected_bytes.push_back(b);
      b.data     = bcd_byte(nv);
      b.is_last  = 1'b1;
      expected_bytes.push_back(b);
    endfunction

    // Compare one output transfer with the oldest expected byte
    function void check_byte(logic [7:0] data, logic user, logic last);
      bus_byte_t e;
      if (expected_bytes.size() == 0) begin
        $error("unexpected output byte %02h (first %0b last %0b)", data, user, last);
        errors++;
        return;
      end
      e = expected_bytes.pop_front();
      if (data !== e.data) begin
        $error("bus_byte: expected %02h, got %02h", e.data, data);
        errors++;
      end
      if (user !== e.is_first) begin
        $error("first_byte: expected %0b, got %0b", e.is_first, user);
        errors++;
      end
      if (last !== e.is_last) begin
        $error("last_byte: expected %0b, got %0b", e.is_last, last);
        errors++;
      end
    endfunction

    function int pending();
      return expected_bytes.size();
    endfunction
  endclass

  logic             clk_i;
  logic             rst_ni;
  logic [DataW-1:0] s_data;
  logic             s_valid;
  logic             s_axis_tready_o;
  logic [7:0]       m_axis_tdata_o;
  logic             m_axis_tuser_o;
  logic             m_axis_tlast_o;
  logic             m_axis_tvalid_o;
  logic             m_ready;

  write_seq_board   board;
  int               gap_pct   = 28;
  int               stall_pct = 28;
  int               idle_cycles = 0;

  calendar_field_adjust uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tdata_i  (s_data),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_axis_tready_o),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_ready)
  );

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic cfa_req_t make_req(field_sel_e sel, bit up,
                                        int unsigned minute, int unsigned hour,
                                        int unsigned wday, int unsigned date,
                                        int unsigned month, int unsigned year);
    cfa_req_t r;
    r.field_select = sel;
    r.go_up        = up;
    r.cur_minute   = 6'(minute);
    r.cur_hour     = 5'(hour);
    r.cur_weekday  = 3'(wday);
    r.cur_date     = 5'(date);
    r.cur_month    = 4'(month);
    r.cur_year     = 7'(year);
    return r;
  endfunction

  // Mostly a valid calendar time; the rest raw across the full field widths
  function automatic cfa_req_t random_req();
    cfa_req_t r;
    r.field_select = 3'($urandom_range(7));
    r.go_up        = 1'($urandom_range(1));
    if ($urandom_range(99) < 75) begin
      r.cur_minute  = 6'($urandom_range(59));
      r.cur_hour    = 5'($urandom_range(23));
      r.cur_weekday = 3'($urandom_range(7, 1));
      r.cur_date    = 5'($urandom_range(31, 1));
      r.cur_month   = 4'($urandom_range(12, 1));
      r.cur_year    = 7'($urandom_range(99));
    end else begin
      r.cur_minute  = 6'($urandom());
      r.cur_hour    = 5'($urandom());
      r.cur_weekday = 3'($urandom());
      r.cur_date    = 5'($urandom());
      r.cur_month   = 4'($urandom());
      r.cur_year    = 7'($urandom());
    end
    return r;
  endfunction

  // Offer one request on s_axis, with random gaps, until it is transferred
  task automatic send_request(cfa_req_t r);
    @(negedge clk_i);
    while ($urandom_range(99) < gap_pct) begin
      s_valid <= 1'b0;
      @(negedge clk_i);
    end
    s_valid <= 1'b1;
    s_data  <= DataW'(r);
    do @(posedge clk_i); while (!s_axis_tready_o);
    board.note_request(r);
  endtask

  // Output side: random back-pressure, check each transfer
  initial begin
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      m_ready <= ($urandom_range(99) >= stall_pct);
      @(posedge clk_i);
      if (m_axis_tvalid_o && m_ready) begin
        board.check_byte(m_axis_tdata_o, m_axis_tuser_o, m_axis_tlast_o);
      end
    end
  end

  // Watchdog: ends the run when no transfer happens for too long
  always @(posedge clk_i) begin
    if ((s_valid && s_axis_tready_o) || (m_axis_tvalid_o && m_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Reset, directed requests, random requests, drain
  initial begin
    board   = new();
    rst_ni  = 1'b0;
    s_valid = 1'b0;
    s_data  = '0;
    m_ready = 1'b0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // no field selected, and seconds set up / down
    send_request(make_req(SEL_NONE,    1, 0, 0, 1, 1, 1, 0));
    send_request(make_req(SEL_NONE,    0, 63, 31, 7, 31, 15, 127));
    send_request(make_req(SEL_SECOND,  1, 30, 12, 3, 15, 6, 50));
    send_request(make_req(SEL_SECOND,  0, 30, 12, 3, 15, 6, 50));
    // year wrap both ways, and past the top
    send_request(make_req(SEL_YEAR,    1, 0, 0, 1, 1, 1, 99));
    send_request(make_req(SEL_YEAR,    0, 0, 0, 1, 1, 1, 1));
    send_request(make_req(SEL_YEAR,    0, 0, 0, 1, 1, 1, 0));
    send_request(make_req(SEL_YEAR,    0, 0, 0, 1, 1, 1, 127));
    // month wrap and out-of-range months
    send_request(make_req(SEL_MONTH,   1, 0, 0, 1, 1, 12, 20));
    send_request(make_req(SEL_MONTH,   0, 0, 0, 1, 1, 1, 20));
    send_request(make_req(SEL_MONTH,   0, 0, 0, 1, 1, 0, 20));
    send_request(make_req(SEL_MONTH,   0, 0, 0, 1, 1, 15, 20));
    // date at month ends, leap and common February, odd dates
    send_request(make_req(SEL_DATE,    1, 0, 0, 1, 28, 2, 23));
    send_request(make_req(SEL_DATE,    1, 0, 0, 1, 29, 2, 24));
    send_request(make_req(SEL_DATE,    1, 0, 0, 1, 31, 4, 24));
    send_request(make_req(SEL_DATE,    0, 0, 0, 1, 1, 3, 24));
    send_request(make_req(SEL_DATE,    0, 0, 0, 1, 0, 2, 0));
    send_request(make_req(SEL_DATE,    1, 0, 0, 1, 30, 14, 1));
    // weekday wrap and out-of-range weekdays
    send_request(make_req(SEL_WEEKDAY, 1, 0, 0, 7, 1, 1, 0));
    send_request(make_req(SEL_WEEKDAY, 0, 0, 0, 1, 1, 1, 0));
    send_request(make_req(SEL_WEEKDAY, 1, 0, 0, 0, 1, 1, 0));
    send_request(make_req(SEL_WEEKDAY, 0, 0, 0, 0, 1, 1, 0));
    // hour and minute wrap, and values beyond the top
    send_request(make_req(SEL_HOUR,    1, 0, 23, 1, 1, 1, 0));
    send_request(make_req(SEL_HOUR,    0, 0, 31, 1, 1, 1, 0));
    send_request(make_req(SEL_MINUTE,  1, 59, 0, 1, 1, 1, 0));
    send_request(make_req(SEL_MINUTE,  0, 0, 0, 1, 1, 1, 0));
    send_request(make_req(SEL_MINUTE,  0, 63, 0, 1, 1, 1, 0));

    // random requests, with a long pause-free stretch in the middle
    for (int i = 0; i < RandomCount; i++) begin
      if (i == 120) begin
        gap_pct   = 0;
        stall_pct = 0;
      end else if (i == 200) begin
        gap_pct   = 28;
        stall_pct = 28;
      end
      send_request(random_req());
    end
    @(negedge clk_i);
    s_valid <= 1'b0;

    while (board.pending() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (board.errors == 0 && board.pending() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/cfa_pkg.sv
rtl/cfa_step.sv
rtl/calendar_field_adjust.sv
tb/sv/tb.sv
